// ===== hdl/hsb_to_rgb_convert_top_assert.svh =====
// ---------------------------------------------------------------------------
// hsb to rgb assertion macros
// concurrent checks used by the conversion pipeline, clocked on clk
// and held off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef HSB_TO_RGB_CONVERT_TOP_ASSERT_SVH
`define HSB_TO_RGB_CONVERT_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define HSBRGB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsb_to_rgb assertion failed");

// consequent checked in the cycle after the antecedent
`define HSBRGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsb_to_rgb assertion failed");

`endif

// ===== hdl/hsbrgb_pkg.sv =====
// ---------------------------------------------------------------------------
// hsb to rgb package
// sector codes, stage records and reciprocal constants for the pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package hsbrgb_pkg;

  // hexcone sectors, sixty degrees each
  typedef enum logic [2:0] {
    SECT_RED,
    SECT_YELLOW,
    SECT_GREEN,
    SECT_CYAN,
    SECT_BLUE,
    SECT_MAGENTA
  } sector_t;

  localparam logic [8:0]  HUE_MAX  = 9'd360;
  localparam logic [6:0]  PCT_MAX  = 7'd100;
  localparam logic [12:0] FULL_TURN = 13'd6000;  // 60 degrees times 100 percent
  localparam logic [5:0]  SECT_DEG = 6'd60;

  // floor(x / d) as (x * m) >> k, exact over the value ranges used here
  localparam logic [15:0] RECIP_V  = 16'd41944;        // d = 100,    x < 2^15
  localparam int          SHIFT_V  = 22;
  localparam logic [22:0] RECIP_T0 = 23'd6871948;      // d = 10000,  x < 2^22
  localparam int          SHIFT_T0 = 36;
  localparam logic [28:0] RECIP_T  = 29'd469124962;    // d = 600000, x < 2^28
  localparam int          SHIFT_T  = 48;

  typedef struct packed {
    sector_t     sector;
    logic [5:0]  offset;
    logic [6:0]  sat;
    logic [14:0] scaled;
    logic [7:0]  alpha;
  } s1_t;

  typedef struct packed {
    sector_t     sector;
    logic        gray;
    logic [6:0]  m0;
    logic [12:0] m1;
    logic [12:0] m2;
    logic [14:0] scaled;
    logic [30:0] vprod;
    logic [7:0]  alpha;
  } s2_t;

  typedef struct packed {
    sector_t     sector;
    logic        gray;
    logic [7:0]  v;
    logic [21:0] p0;
    logic [27:0] p1;
    logic [27:0] p2;
    logic [7:0]  alpha;
  } s3_t;

endpackage

`default_nettype wire

// ===== hdl/hsbrgb_prep.sv =====
// ---------------------------------------------------------------------------
// hsb to rgb front end
// clamps saturation and brightness, wraps an out-of-range hue to zero, finds
// the hue sector and offset and scales brightness by 255
// ---------------------------------------------------------------------------
`default_nettype none

module hsbrgb_prep
  import hsbrgb_pkg::*;
(
  input  wire logic [8:0] hue,
  input  wire logic [6:0] saturation,
  input  wire logic [6:0] brightness,
  input  wire logic [7:0] alpha,
  output s1_t             prep
);

  logic [8:0]  h;
  logic [8:0]  base;
  logic [8:0]  diff;
  logic [6:0]  b;
  sector_t     sector;

  // a full turn and anything above wraps to zero
  assign h = (hue >= HUE_MAX) ? '0 : hue;
  assign b = (brightness > PCT_MAX) ? PCT_MAX : brightness;

  always_comb begin
    if (h >= 9'd300) begin
      sector = SECT_MAGENTA;
      base   = 9'd300;
    end else if (h >= 9'd240) begin
      sector = SECT_BLUE;
      base   = 9'd240;
    end else if (h >= 9'd180) begin
      sector = SECT_CYAN;
      base   = 9'd180;
    end else if (h >= 9'd120) begin
      sector = SECT_GREEN;
      base   = 9'd120;
    end else if (h >= 9'd60) begin
      sector = SECT_YELLOW;
      base   = 9'd60;
    end else begin
      sector = SECT_RED;
      base   = 9'd0;
    end
  end

  assign diff = h - base;

  assign prep.sector = sector;
  assign prep.offset = diff[5:0];
  assign prep.sat    = (saturation > PCT_MAX) ? PCT_MAX : saturation;
  // b * 255 as b * 256 - b
  assign prep.scaled = {b, 8'd0} - {8'd0, b};
  assign prep.alpha  = alpha;

endmodule

`default_nettype wire

// ===== hdl/hsb_to_rgb_convert_top.sv =====
// an accepted request passes through s1, s2, s3 and the output register to out_valid
// throughput: one pixel per clock while out_stall is low; each of the four register stages holds
//   one pixel and moves on whenever the stage after it has room
// reset: rst_n low clears every stage valid bit, payload is left as is
// the path is set by the tint products and the reciprocal multiplies
// ---------------------------------------------------------------------------
// hsb to rgb converter
// hexcone hue/saturation/brightness to 8-bit rgb, alpha passed through
// ---------------------------------------------------------------------------
`default_nettype none

`include "hsb_to_rgb_convert_top_assert.svh"

module hsb_to_rgb_convert_top
  import hsbrgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [8:0] in_hue,
  input  wire logic [6:0] in_saturation,
  input  wire logic [6:0] in_brightness,
  input  wire logic [7:0] in_alpha_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha_out
);

  s1_t  prep;
  s1_t  s1_r;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  logic [44:0] q0;
  logic [56:0] q1, q2;
  logic [7:0]  t0, t1, t2;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;
  logic [7:0]  out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic [12:0] sat_off;
  logic [12:0] sat_rest;
  logic [5:0]  rest;

  hsbrgb_prep u_prep (
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .alpha      (in_alpha_in),
    .prep       (prep)
  );

  // a stage takes new data when it is empty or its contents move on
  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy3     = !s3_valid_r || rdy_out;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  // stage 2: tint multipliers and brightness reciprocal product
  assign rest     = SECT_DEG - s1_r.offset;
  assign sat_off  = 13'(s1_r.sat) * s1_r.offset;
  assign sat_rest = 13'(s1_r.sat) * rest;

  always_comb begin
    s2_nxt.sector = s1_r.sector;
    s2_nxt.gray   = (s1_r.sat == '0);
    s2_nxt.m0     = PCT_MAX - s1_r.sat;
    s2_nxt.m1     = FULL_TURN - sat_off;
    s2_nxt.m2     = FULL_TURN - sat_rest;
    s2_nxt.scaled = s1_r.scaled;
    s2_nxt.vprod  = 31'(s1_r.scaled) * 31'(RECIP_V);
    s2_nxt.alpha  = s1_r.alpha;
  end

  // stage 3: scaled brightness times each multiplier
  always_comb begin
    s3_nxt.sector = s2_r.sector;
    s3_nxt.gray   = s2_r.gray;
    s3_nxt.v      = 8'(s2_r.vprod >> SHIFT_V);
    s3_nxt.p0     = 22'(s2_r.scaled) * 22'(s2_r.m0);
    s3_nxt.p1     = 28'(s2_r.scaled) * 28'(s2_r.m1);
    s3_nxt.p2     = 28'(s2_r.scaled) * 28'(s2_r.m2);
    s3_nxt.alpha  = s2_r.alpha;
  end

  // output stage: constant division by reciprocal, then channel pick
  assign q0 = 45'(s3_r.p0) * 45'(RECIP_T0);
  assign q1 = 57'(s3_r.p1) * 57'(RECIP_T);
  assign q2 = 57'(s3_r.p2) * 57'(RECIP_T);
  assign t0 = 8'(q0 >> SHIFT_T0);
  assign t1 = 8'(q1 >> SHIFT_T);
  assign t2 = 8'(q2 >> SHIFT_T);

  always_comb begin
    if (s3_r.gray) begin
      red_nxt   = s3_r.v;
      green_nxt = s3_r.v;
      blue_nxt  = s3_r.v;
    end else begin
      case (s3_r.sector)
        SECT_YELLOW: begin
          red_nxt = t1;     green_nxt = s3_r.v; blue_nxt = t0;
        end
        SECT_GREEN: begin
          red_nxt = t0;     green_nxt = s3_r.v; blue_nxt = t2;
        end
        SECT_CYAN: begin
          red_nxt = t0;     green_nxt = t1;     blue_nxt = s3_r.v;
        end
        SECT_BLUE: begin
          red_nxt = t2;     green_nxt = t0;     blue_nxt = s3_r.v;
        end
        SECT_MAGENTA: begin
          red_nxt = s3_r.v; green_nxt = t0;     blue_nxt = t1;
        end
        default: begin
          red_nxt = s3_r.v; green_nxt = t2;     blue_nxt = t0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= in_valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
      if (rdy_out) out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= prep;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
    if (rdy_out) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
      out_alpha_r <= s3_r.alpha;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_alpha_out = out_alpha_r;

  // an accepted request lands in the first stage
  `HSBRGB_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, s1_valid_r)
  // a held stage keeps its pixel
  `HSBRGB_ASSERT_NEXT(a_s3_held, s3_valid_r && !rdy3, s3_valid_r)
  // a grey pixel leaves with equal channels
  `HSBRGB_ASSERT_NEXT(a_grey_out, s3_valid_r && rdy_out && s3_r.gray,
    out_red_r == out_green_r && out_green_r == out_blue_r)

endmodule

`default_nettype wire

// ===== tb/sv/tb_hsb_to_rgb_convert_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsb to rgb converter testbench
// drives hue/saturation/brightness pixels through the converter, predicts
// each rgb result with a local integer model and checks results in order,
// with directed corner pixels first and then random pixels under idling and output stalls
// ---------------------------------------------------------------------------

module tb_hsb_to_rgb_convert_top;
  import hsbrgb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [8:0] in_hue        = '0;
  logic [6:0] in_saturation = '0;
  logic [6:0] in_brightness = '0;
  logic [7:0] in_alpha_in   = '0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha_out;

  rgba_t       expected_px[$];
  int          error_count   = 0;
  int unsigned cycle_count   = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;

  always #6 clk = ~clk;

  hsb_to_rgb_convert_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha_out (out_alpha_out)
  );

  // hexcone conversion, each channel one truncating integer quotient
  function automatic rgba_t hsb_to_rgba(input logic [8:0] hue, input logic [6:0] sat,
                                        input logic [6:0] bri, input logic [7:0] alpha);
    int unsigned h, s, b, off, scaled, v, t0, t1, t2;
    sector_t     sect;
    rgba_t       px;
    h = (hue > HUE_MAX) ? HUE_MAX : hue;
    s = (sat > PCT_MAX) ? PCT_MAX : sat;
    b = (bri > PCT_MAX) ? PCT_MAX : bri;
    // a full turn wraps back to red
    if (h == HUE_MAX) h = 0;
    sect   = sector_t'(h / 60);
    off    = h - 60 * (h / 60);
    scaled = b * 255;
    v  = scaled / 100;
    t0 = scaled * (100 - s) / 10000;
    t1 = scaled * (6000 - s * off) / 600000;
    t2 = scaled * (6000 - s * (60 - off)) / 600000;
    px.alpha = alpha;
    if (s == 0) begin
      px.red = v[7:0]; px.green = v[7:0]; px.blue = v[7:0];
    end else begin
      case (sect)
        SECT_YELLOW: begin
          px.red = t1[7:0]; px.green = v[7:0];  px.blue = t0[7:0];
        end
        SECT_GREEN: begin
          px.red = t0[7:0]; px.green = v[7:0];  px.blue = t2[7:0];
        end
        SECT_CYAN: begin
          px.red = t0[7:0]; px.green = t1[7:0]; px.blue = v[7:0];
        end
        SECT_BLUE: begin
          px.red = t2[7:0]; px.green = t0[7:0]; px.blue = v[7:0];
        end
        SECT_MAGENTA: begin
          px.red = v[7:0];  px.green = t0[7:0]; px.blue = t1[7:0];
        end
        default: begin
          px.red = v[7:0];  px.green = t2[7:0]; px.blue = t0[7:0];
        end
      endcase
    end
    return px;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    rgba_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_px.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d alpha %0d",
               out_red, out_green, out_blue, out_alpha_out);
        error_count++;
      end else begin
        exp_px = expected_px.pop_front();
        check_field("red", exp_px.red, out_red);
        check_field("green", exp_px.green, out_green);
        check_field("blue", exp_px.blue, out_blue);
        check_field("alpha_out", exp_px.alpha, out_alpha_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL hsb_to_rgb_convert_top");
      $finish;
    end
  end

  // called just after a rising edge, returns just after the accepting edge
  task automatic send_pixel(input logic [8:0] hue, input logic [6:0] sat,
                            input logic [6:0] bri, input logic [7:0] alpha);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= bri;
    in_alpha_in   <= alpha;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_px.push_back(hsb_to_rgba(hue, sat, bri, alpha));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both sides of every sector boundary, at full colour and at reduced saturation and brightness
  task automatic test_sector_edges();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_pixel(9'd0,   7'd100, 7'd100, 8'd0);
    send_pixel(9'd59,  7'd100, 7'd100, 8'd255);
    send_pixel(9'd60,  7'd100, 7'd100, 8'd1);
    send_pixel(9'd119, 7'd100, 7'd100, 8'd128);
    send_pixel(9'd120, 7'd100, 7'd100, 8'd170);
    send_pixel(9'd179, 7'd100, 7'd100, 8'd85);
    send_pixel(9'd180, 7'd50,  7'd100, 8'd255);
    send_pixel(9'd239, 7'd50,  7'd100, 8'd0);
    send_pixel(9'd240, 7'd37,  7'd73,  8'd15);
    send_pixel(9'd299, 7'd37,  7'd73,  8'd240);
    send_pixel(9'd300, 7'd1,   7'd99,  8'd7);
    send_pixel(9'd359, 7'd99,  7'd1,   8'd200);
    drain_results();
  endtask

  // full turn, hue/saturation/brightness above range, dark pixels
  task automatic test_wrap_and_clamp();
    send_pixel(9'd360, 7'd100, 7'd100, 8'd255);
    send_pixel(9'd361, 7'd80,  7'd90,  8'd0);
    send_pixel(9'd511, 7'd127, 7'd127, 8'd255);
    send_pixel(9'd200, 7'd101, 7'd101, 8'd170);
    send_pixel(9'd90,  7'd127, 7'd0,   8'd85);
    send_pixel(9'd330, 7'd60,  7'd127, 8'd33);
    drain_results();
  endtask

  task automatic test_gray();
    send_pixel(9'd0,   7'd0, 7'd100, 8'd255);
    send_pixel(9'd150, 7'd0, 7'd50,  8'd0);
    send_pixel(9'd270, 7'd0, 7'd0,   8'd99);
    send_pixel(9'd511, 7'd0, 7'd127, 8'd128);
    drain_results();
  endtask

  task automatic test_random_pixels(input int count, input int idle_pct,
                                    input int stall_pct_in);
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] bri;
    int         pick;
    send_idle_pct = idle_pct;
    stall_pct     = stall_pct_in;
    repeat (count) begin
      hue  = ($urandom_range(99) < 85) ? 9'($urandom_range(360)) : 9'($urandom);
      pick = $urandom_range(99);
      if (pick < 10) sat = '0;
      else if (pick < 80) sat = 7'($urandom_range(100));
      else sat = 7'($urandom);
      pick = $urandom_range(99);
      if (pick < 5) bri = '0;
      else if (pick < 80) bri = 7'($urandom_range(100));
      else bri = 7'($urandom);
      send_pixel(hue, sat, bri, 8'($urandom));
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sector_edges();
    test_wrap_and_clamp();
    test_gray();
    test_random_pixels(212, 0, 0);
    test_random_pixels(212, 47, 0);
    test_random_pixels(212, 0, 47);
    test_random_pixels(214, 13, 13);
    stall_pct = 0;
    if (error_count == 0) begin
      $display("PASS hsb_to_rgb_convert_top");
    end else begin
      $display("FAIL hsb_to_rgb_convert_top");
    end
    $finish;
  end

endmodule
